FILE: src/gsr_pkg.sv
// shared types, constants and lookup tables of the gauge stepper ramp controller
package gsr_pkg;

  localparam int ACCEL_POINTS = 5;
  localparam int TOP_VELOCITY = 300;
  localparam int RAMP_PTS     = (ACCEL_POINTS > 5) ? 5 : ACCEL_POINTS;

  localparam int POS_W      = 32;
  localparam int VEL_W      = 9;
  localparam int DELAY_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [1:0] op_t;
  localparam op_t OP_TICK   = 2'd0;
  localparam op_t OP_MOVE   = 2'd1;
  localparam op_t OP_REZERO = 2'd2;
  localparam op_t OP_SPARE  = 2'd3;

  typedef logic [1:0] dir_t;
  localparam dir_t DIR_NONE = 2'd0;
  localparam dir_t DIR_UP   = 2'd1;
  localparam dir_t DIR_DOWN = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FOUR_STATE = 3'd0;
  localparam cfg_idx_t CFG_WRAP       = 3'd1;
  localparam cfg_idx_t CFG_SPR        = 3'd2;
  localparam cfg_idx_t CFG_MIN        = 3'd3;
  localparam cfg_idx_t CFG_MAX        = 3'd4;
  localparam cfg_idx_t CFG_DEADBAND   = 3'd5;
  localparam cfg_idx_t CFG_HOME       = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic div_start;
    logic div_use_target;
    logic cap_cur;
    logic wrap_commit;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic wrap_on;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic logic [VEL_W-1:0] ramp_threshold(input logic [2:0] idx);
    case (idx)
      3'd0:    ramp_threshold = 9'd20;
      3'd1:    ramp_threshold = 9'd50;
      3'd2:    ramp_threshold = 9'd100;
      3'd3:    ramp_threshold = 9'd150;
      default: ramp_threshold = 9'd300;
    endcase
  endfunction

  function automatic logic [DELAY_W-1:0] ramp_delay(input logic [2:0] idx);
    case (idx)
      3'd0:    ramp_delay = 12'd3000;
      3'd1:    ramp_delay = 12'd1500;
      3'd2:    ramp_delay = 12'd1000;
      3'd3:    ramp_delay = 12'd800;
      default: ramp_delay = 12'd600;
    endcase
  endfunction

  function automatic logic [3:0] seq_six(input logic [2:0] p);
    case (p)
      3'd0:    seq_six = 4'h9;
      3'd1:    seq_six = 4'h1;
      3'd2:    seq_six = 4'h7;
      3'd3:    seq_six = 4'h6;
      3'd4:    seq_six = 4'hE;
      default: seq_six = 4'h8;
    endcase
  endfunction

  function automatic logic [3:0] seq_four(input logic [1:0] p);
    case (p)
      2'd0:    seq_four = 4'h5;
      2'd1:    seq_four = 4'h6;
      2'd2:    seq_four = 4'hA;
      default: seq_four = 4'h9;
    endcase
  endfunction

endpackage

FILE: src/gsr_if.sv
// valid/ready channel interfaces for items and results
interface gsr_in_if;
  import gsr_pkg::*;
  logic               valid;
  logic               ready;
  op_t                operation;
  logic signed [31:0] target_position;
  logic [15:0]        elapsed_us;
  modport source (output valid, operation, target_position, elapsed_us, input ready);
  modport sink   (input valid, operation, target_position, elapsed_us, output ready);
endinterface

interface gsr_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         coil_mask;
  logic signed [31:0] reported_position;
  logic               moving;
  logic               stepped;
  modport source (output valid, coil_mask, reported_position, moving, stepped, input ready);
  modport sink   (input valid, coil_mask, reported_position, moving, stepped, output ready);
endinterface

FILE: src/gsr_rem.sv
// bit-serial remainder unit, floor modulo of a signed word by an unsigned revolution
module gsr_rem (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] x,
  input  logic [15:0]        r,
  output logic               done,
  output logic [15:0]        rem
);
  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] a;
  logic [15:0] part;
  logic        neg;
  logic [16:0] trial;

  assign trial = {part, a[31]};
  assign rem   = (neg && part != 16'd0) ? r - part : part;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a    <= x[31] ? 32'(-x) : 32'(x);
      neg  <= x[31];
      part <= '0;
    end else if (busy) begin
      a <= {a[30:0], 1'b0};
      if (trial >= {1'b0, r}) begin
        part <= 16'(trial - {1'b0, r});
      end else begin
        part <= trial[15:0];
      end
    end
  end
endmodule

FILE: src/gsr_datapath.sv
// ramp datapath: configuration, motor state, step and target arithmetic, result register
module gsr_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gsr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  gsr_pkg::op_t                      operation,
  input  logic signed [31:0]                target_position,
  input  logic [15:0]                       elapsed_us,
  input  gsr_pkg::cmd_t                     cmd,
  output gsr_pkg::sts_t                     sts,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [3:0]                        coil_mask,
  output logic signed [31:0]                reported_position,
  output logic                              moving,
  output logic                              stepped
);
  import gsr_pkg::*;

  localparam logic [VEL_W-1:0] TOP_V = VEL_W'(TOP_VELOCITY);

  logic               cfg_four, cfg_wrap;
  logic [15:0]        cfg_spr;
  logic signed [15:0] cfg_min, cfg_max, cfg_home;
  logic [7:0]         cfg_db;

  logic signed [31:0] cur_step, tgt_step;
  logic [VEL_W-1:0]   velocity;
  dir_t               dir;
  logic               stopped;
  logic [2:0]         phase;
  logic [15:0]        elapsed;
  logic [DELAY_W-1:0] step_delay;

  op_t                op_q;
  logic signed [31:0] pos_q;
  logic [15:0]        us_q;
  logic [15:0]        cur_m;
  logic               stepped_q;

  logic               div_done;
  logic [15:0]        div_rem;

  gsr_rem u_rem (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .x     (cmd.div_use_target ? pos_q : cur_step),
    .r     (cfg_spr),
    .done  (div_done),
    .rem   (div_rem)
  );

  logic               wrap_on;
  logic [2:0]         seq_n, eff_p, phase_new;
  logic [3:0]         coil;
  logic [16:0]        sum;
  logic [15:0]        sat;
  logic               fire, settle, up, lt;
  dir_t               dir_new;
  logic [VEL_W-1:0]   vel_base, vel_new;
  logic signed [31:0] cur_new, delta;
  logic [2:0]         idx;
  logic               go;
  logic signed [31:0] lo, hi, clamp_t, wrap_t, move_t;
  logic signed [16:0] diff_a, diff_b, diff_c;
  logic signed [32:0] d33;
  logic [32:0]        absd;
  logic               commit;

  assign wrap_on = cfg_wrap && (cfg_spr != 16'd0);
  assign seq_n   = cfg_four ? 3'd4 : 3'd6;
  assign eff_p   = (phase >= seq_n) ? phase - 3'd4 : phase;
  assign coil    = cfg_four ? seq_four(eff_p[1:0]) : seq_six(eff_p);

  // tick accumulation
  assign sum    = {1'b0, elapsed} + {1'b0, us_q};
  assign sat    = sum[16] ? 16'hFFFF : sum[15:0];
  assign fire   = !stopped && (sat >= {4'd0, step_delay});
  assign settle = (cur_step == tgt_step) && (velocity == '0);

  // one step of the ramp
  assign lt        = cur_step < tgt_step;
  assign up        = (velocity == '0) ? lt : (dir == DIR_UP);
  assign dir_new   = (velocity == '0) ? (lt ? DIR_UP : DIR_DOWN) : dir;
  assign vel_base  = (velocity == '0) ? VEL_W'(1) : velocity;
  assign cur_new   = up ? cur_step + 32'sd1 : cur_step - 32'sd1;
  assign phase_new = up ? ((eff_p + 3'd1 == seq_n) ? 3'd0 : eff_p + 3'd1)
                        : ((eff_p == 3'd0) ? seq_n - 3'd1 : eff_p - 3'd1);
  assign delta     = up ? tgt_step - cur_new : cur_new - tgt_step;

  always_comb begin
    if (delta > 32'sd0) begin
      if (delta < $signed({23'd0, vel_base})) begin
        vel_new = vel_base - VEL_W'(1);
      end else if (vel_base < TOP_V) begin
        vel_new = vel_base + VEL_W'(1);
      end else begin
        vel_new = vel_base;
      end
    end else begin
      vel_new = vel_base - VEL_W'(1);
    end
  end

  always_comb begin
    idx = 3'd0;
    go  = 1'b1;
    for (int j = 0; j < RAMP_PTS - 1; j++) begin
      if (go && ramp_threshold(3'(j)) < vel_new) begin
        idx = idx + 3'd1;
      end else begin
        go = 1'b0;
      end
    end
  end

  // target selection: clamp, or shortest path around the revolution
  assign lo      = 32'(cfg_min);
  assign hi      = 32'(cfg_max);
  assign clamp_t = (pos_q < lo) ? lo : ((pos_q > hi) ? hi : pos_q);
  assign diff_a  = $signed({1'b0, div_rem}) - $signed({1'b0, cur_m});
  assign diff_b  = (diff_a < 17'sd0) ? diff_a + $signed({1'b0, cfg_spr}) : diff_a;
  assign diff_c  = (diff_b > $signed({2'b0, cfg_spr[15:1]}))
                 ? diff_b - $signed({1'b0, cfg_spr}) : diff_b;
  assign wrap_t  = cur_step + 32'(diff_c);
  assign move_t  = cmd.wrap_commit ? wrap_t : clamp_t;
  assign d33     = 33'(move_t) - 33'(tgt_step);
  assign absd    = d33[32] ? 33'(-d33) : 33'(d33);
  assign commit  = absd > {25'd0, cfg_db};

  assign sts.op       = op_q;
  assign sts.wrap_on  = wrap_on;
  assign sts.div_done = div_done;
  assign sts.out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_four <= 1'b0;
      cfg_wrap <= 1'b0;
      cfg_spr  <= '0;
      cfg_min  <= 16'sh8000;
      cfg_max  <= 16'sh7FFF;
      cfg_db   <= '0;
      cfg_home <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FOUR_STATE: cfg_four <= cfg_data[0];
        CFG_WRAP:       cfg_wrap <= cfg_data[0];
        CFG_SPR:        cfg_spr  <= cfg_data;
        CFG_MIN:        cfg_min  <= $signed(cfg_data);
        CFG_MAX:        cfg_max  <= $signed(cfg_data);
        CFG_DEADBAND:   cfg_db   <= cfg_data[7:0];
        CFG_HOME:       cfg_home <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_step   <= '0;
      tgt_step   <= '0;
      velocity   <= '0;
      dir        <= DIR_NONE;
      stopped    <= 1'b1;
      phase      <= '0;
      elapsed    <= '0;
      step_delay <= '0;
    end else begin
      if (cmd.exec) begin
        case (op_q)
          OP_TICK: begin
            if (fire) begin
              elapsed <= '0;
              if (settle) begin
                stopped <= 1'b1;
                dir     <= DIR_NONE;
              end else begin
                cur_step   <= cur_new;
                phase      <= phase_new;
                velocity   <= vel_new;
                dir        <= dir_new;
                step_delay <= ramp_delay(idx);
              end
            end else begin
              elapsed <= sat;
            end
          end
          OP_REZERO: cur_step <= 32'(cfg_home);
          default: ;
        endcase
      end
      if (((cmd.exec && op_q == OP_MOVE) || cmd.wrap_commit) && commit) begin
        tgt_step <= move_t;
        if (stopped) begin
          stopped    <= 1'b0;
          elapsed    <= '0;
          step_delay <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= operation;
      pos_q     <= target_position;
      us_q      <= elapsed_us;
      stepped_q <= 1'b0;
    end else if (cmd.exec && op_q == OP_TICK) begin
      stepped_q <= fire && !settle;
    end
    if (cmd.cap_cur) begin
      cur_m <= div_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      coil_mask         <= coil;
      reported_position <= wrap_on ? $signed({16'd0, div_rem}) : cur_step;
      moving            <= !stopped;
      stepped           <= stepped_q;
    end
  end
endmodule

FILE: src/gsr_ctrl.sv
// controller state machine sequencing one item through the datapath
module gsr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  gsr_pkg::sts_t sts,
  output gsr_pkg::cmd_t cmd
);
  import gsr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_CUR   = 3'd2;
  localparam logic [2:0] S_TGT   = 3'd3;
  localparam logic [2:0] S_WRAP  = 3'd4;
  localparam logic [2:0] S_REPGO = 3'd5;
  localparam logic [2:0] S_REP   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state, state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.op == OP_MOVE && sts.wrap_on) begin
          cmd.div_start = 1'b1;
          state_next    = S_CUR;
        end else begin
          cmd.exec   = 1'b1;
          state_next = sts.wrap_on ? S_REPGO : S_DONE;
        end
      end
      S_CUR: begin
        if (sts.div_done) begin
          cmd.cap_cur        = 1'b1;
          cmd.div_start      = 1'b1;
          cmd.div_use_target = 1'b1;
          state_next         = S_TGT;
        end
      end
      S_TGT: begin
        if (sts.div_done) begin
          state_next = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd.wrap_commit = 1'b1;
        cmd.div_start   = 1'b1;
        state_next      = S_REP;
      end
      S_REPGO: begin
        cmd.div_start = 1'b1;
        state_next    = S_REP;
      end
      S_REP: begin
        if (sts.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

FILE: src/gauge_stepper_ramp_controller.sv
// gauge stepper ramp controller, top level
// wrap off: the item executes, loads the result register, then the next item can transfer
// wrap on: a tick or re-zero runs one remainder pass for the reported position
// a move with wrap on runs three remainder passes in turn: current position, target, result
// the serial remainder unit works one quotient bit per cycle; a held result adds its stall
// synchronous reset: position, target, velocity, phase and timers clear, motor stopped
module gauge_stepper_ramp_controller (
  input  logic                           clk,
  input  logic                           rst,
  gsr_in_if.sink                         item,
  gsr_out_if.source                      result,
  input  logic                           cfg_we,
  input  logic [gsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gsr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: transfer in, run tick/move/re-zero, remainder passes, hand to result register
  gsr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // state, arithmetic and the result register; the result register lets a new item
  // transfer in while the previous result still waits on the output side
  gsr_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .operation         (item.operation),
    .target_position   (item.target_position),
    .elapsed_us        (item.elapsed_us),
    .cmd               (cmd),
    .sts               (sts),
    .res_valid         (result.valid),
    .res_ready         (result.ready),
    .coil_mask         (result.coil_mask),
    .reported_position (result.reported_position),
    .moving            (result.moving),
    .stepped           (result.stepped)
  );
endmodule

FILE: src/gsr_checker.sv
// port-level checks of the gauge stepper ramp controller, bound to the top level
module gsr_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic moving,
  input logic stepped
);
  // one item in flight: no second transfer right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // a step only happens while a move is in progress
  a_step_moving: assert property (@(posedge clk) disable iff (rst)
    out_valid && stepped |-> moving)
    else $error("step reported on a stopped motor");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind gauge_stepper_ramp_controller gsr_checker u_gsr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .moving    (result.moving),
  .stepped   (result.stepped)
);

FILE: tb/gsr_checker.sv
// result checker for the gauge stepper ramp controller: mirrors config, predicts, compares
module gsr_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  gsr_in_if                              item,
  gsr_out_if                             result,
  input  logic                           cfg_we,
  input  logic [gsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending,
  output int                             checked
);
  import gsr_pkg::*;

  typedef struct packed {
    logic [3:0]  coil_mask;
    logic [31:0] position;
    logic        moving;
    logic        stepped;
  } gauge_out_t;

  localparam int THRESH[5] = '{20, 50, 100, 150, 300};
  localparam int DELAYS[5] = '{3000, 1500, 1000, 800, 600};
  localparam logic [3:0] SIX[6]  = '{4'h9, 4'h1, 4'h7, 4'h6, 4'hE, 4'h8};
  localparam logic [3:0] FOUR[4] = '{4'h5, 4'h6, 4'hA, 4'h9};

  // mirrored registers
  logic        four_state, wrap_on;
  logic [15:0] rev_steps;
  logic signed [15:0] lo_limit, hi_limit, home;
  logic [7:0]  band;

  // motor state
  logic [31:0] cur_pos, tgt_pos;
  int unsigned speed, accum, delay_us, phase;
  dir_t        heading;
  logic        halted;

  gauge_out_t  awaited[$];

  function automatic longint sx32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic int unsigned seq_length();
    return four_state ? 4 : 6;
  endfunction

  function automatic int unsigned live_phase();
    int unsigned p;
    p = phase & 7;
    if (p >= seq_length()) p -= 4;
    return p;
  endfunction

  function automatic logic [3:0] coils();
    return four_state ? FOUR[live_phase() & 3] : SIX[live_phase()];
  endfunction

  function automatic logic wrapping();
    return wrap_on && rev_steps != 0;
  endfunction

  function automatic logic [31:0] shown_pos();
    longint r;
    if (!wrapping()) return cur_pos;
    r = longint'(rev_steps);
    return 32'(((sx32(cur_pos) % r) + r) % r);
  endfunction

  // one ramp advance, returns 1 when a step was taken
  function automatic logic ramp_step();
    longint gap;
    int unsigned n, p, i;
    if (cur_pos == tgt_pos && speed == 0) begin
      halted = 1; heading = DIR_NONE; accum = 0;
      return 0;
    end
    if (speed == 0) begin
      heading = (sx32(cur_pos) < sx32(tgt_pos)) ? DIR_UP : DIR_DOWN;
      speed = 1;
    end
    n = seq_length();
    p = live_phase();
    if (heading == DIR_UP) begin
      cur_pos = cur_pos + 1; phase = (p + 1) % n;
      gap = sx32(tgt_pos - cur_pos);
    end else begin
      cur_pos = cur_pos - 1; phase = (p + n - 1) % n;
      gap = sx32(cur_pos - tgt_pos);
    end
    if (gap > 0) begin
      if (gap < longint'(speed)) speed--;
      else if (speed < TOP_VELOCITY) speed++;
    end else begin
      speed--;
    end
    speed &= 9'h1FF;
    i = 0;
    while (i + 1 < RAMP_PTS && THRESH[i] < speed) i++;
    delay_us = DELAYS[i];
    accum = 0;
    return 1;
  endfunction

  function automatic void retarget(longint req);
    longint r, c, t, d, goal;
    if (wrapping()) begin
      r = longint'(rev_steps);
      c = ((sx32(cur_pos) % r) + r) % r;
      t = ((req % r) + r) % r;
      d = (t - c) % r;
      if (d < 0) d += r;
      if (d > r / 2) d -= r;
      goal = sx32(32'(sx32(cur_pos) + d));
    end else begin
      // inverted limits: a request below the lower limit gets it, any other gets the upper
      goal = req < longint'(lo_limit) ? longint'(lo_limit)
           : (req > longint'(hi_limit) ? longint'(hi_limit) : req);
    end
    d = goal - sx32(tgt_pos);
    if (d < 0) d = -d;
    if (d <= longint'(band)) return;
    tgt_pos = 32'(goal);
    if (halted) begin
      halted = 0; accum = 0; delay_us = 0;
    end
  endfunction

  function automatic gauge_out_t gauge_update(op_t op, logic [31:0] req, logic [15:0] el);
    gauge_out_t e;
    int unsigned sum;
    logic took;
    took = 0;
    case (op)
      OP_TICK: begin
        sum = accum + el;
        accum = sum > 65535 ? 65535 : sum;
        if (!halted && accum >= delay_us) took = ramp_step();
      end
      OP_MOVE:   retarget(sx32(req));
      OP_REZERO: cur_pos = {{16{home[15]}}, home};
      default: ;
    endcase
    e.coil_mask = coils();
    e.position  = shown_pos();
    e.moving    = !halted;
    e.stepped   = took;
    return e;
  endfunction

  always @(posedge clk) begin
    gauge_out_t got, want;
    if (rst) begin
      four_state = 0; wrap_on = 0; rev_steps = 0;
      lo_limit = 16'sh8000; hi_limit = 16'sh7FFF; band = 0; home = 0;
      cur_pos = 0; tgt_pos = 0; speed = 0; accum = 0; delay_us = 0; phase = 0;
      heading = DIR_NONE; halted = 1;
      awaited.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FOUR_STATE: four_state = cfg_data[0];
          CFG_WRAP:       wrap_on    = cfg_data[0];
          CFG_SPR:        rev_steps  = cfg_data;
          CFG_MIN:        lo_limit   = cfg_data;
          CFG_MAX:        hi_limit   = cfg_data;
          CFG_DEADBAND:   band       = cfg_data[7:0];
          CFG_HOME:       home       = cfg_data;
          default: ;
        endcase
      end
      if (item.valid && item.ready)
        awaited.push_back(gauge_update(item.operation, item.target_position, item.elapsed_us));
      if (result.valid && result.ready) begin
        got = '{result.coil_mask, result.reported_position, result.moving, result.stepped};
        checked++;
        if (awaited.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: got %h", $time, got);
        end else begin
          want = awaited.pop_front();
          if (got.coil_mask != want.coil_mask) begin
            errors++;
            $display("%0t: coil_mask expected %h actual %h", $time, want.coil_mask,
                     got.coil_mask);
          end
          if (got.position != want.position) begin
            errors++;
            $display("%0t: reported_position expected %0d actual %0d", $time,
                     $signed(want.position), $signed(got.position));
          end
          if (got.moving != want.moving) begin
            errors++;
            $display("%0t: moving expected %b actual %b", $time, want.moving, got.moving);
          end
          if (got.stepped != want.stepped) begin
            errors++;
            $display("%0t: stepped expected %b actual %b", $time, want.stepped, got.stepped);
          end
        end
      end
    end
    pending = awaited.size();
  end

  initial begin
    errors = 0;
    checked = 0;
    pending = 0;
  end

endmodule

FILE: tb/tb_gauge_stepper_ramp_controller.sv
// testbench top: stimulus, idling, config phases and verdict for the ramp controller
module tb_gauge_stepper_ramp_controller;
  import gsr_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gsr_in_if  item ();
  gsr_out_if result ();

  int errors, pending, checked;
  int send_idle_pct = 0;   // chance per cycle that the sender sits out
  int recv_stall_pct = 0;  // chance per cycle that the receiver holds off
  logic hold_req = 0;      // long receiver hold-off request
  int hold_cycles = 0;
  int cycles = 0;
  int sent = 0;

  always #5 clk = ~clk;

  gauge_stepper_ramp_controller dut (
    .clk, .rst, .item(item.sink), .result(result.source),
    .cfg_we, .cfg_index, .cfg_data
  );

  gsr_result_checker chk (
    .clk, .rst, .item, .result, .cfg_we, .cfg_index, .cfg_data,
    .errors, .pending, .checked
  );

  // receiver side: random stalls, plus one long hold-off counted here
  always @(posedge clk) begin
    if (hold_req && hold_cycles < 400) begin
      result.ready <= 1'b0;
      hold_cycles++;
    end else begin
      result.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycles++;
    if (cycles > 1_000_000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one transfer on the item channel; valid stays up until the next gap
  task automatic put(op_t op, logic [31:0] req, logic [15:0] el);
    while ($urandom_range(99) < send_idle_pct) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid           <= 1'b1;
    item.operation       <= op;
    item.target_position <= req;
    item.elapsed_us      <= el;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    sent++;
  endtask

  // let every result come back, then give a wrap-mode move time to finish
  task automatic drain();
    item.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic setup(logic four, logic wrap, logic [15:0] spr, logic [15:0] lo,
                       logic [15:0] hi, logic [7:0] band, logic [15:0] home);
    write_reg(CFG_FOUR_STATE, {15'd0, four});
    write_reg(CFG_WRAP, {15'd0, wrap});
    write_reg(CFG_SPR, spr);
    write_reg(CFG_MIN, lo);
    write_reg(CFG_MAX, hi);
    write_reg(CFG_DEADBAND, {8'd0, band});
    write_reg(CFG_HOME, home);
    @(posedge clk);
  endtask

  // mostly nearby targets so moves settle, now and then anything at all
  function automatic logic [31:0] pick_target();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(800)) - 400);
    endcase
  endfunction

  function automatic logic [15:0] pick_elapsed();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(65535));
      default: return 16'($urandom_range(3200, 300));
    endcase
  endfunction

  task automatic random_items(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 68)      put(OP_TICK, $urandom, pick_elapsed());
      else if (r < 90) put(OP_MOVE, pick_target(), 16'($urandom));
      else if (r < 96) put(OP_REZERO, $urandom, 16'($urandom));
      else             put(OP_SPARE, $urandom, 16'($urandom));
    end
  endtask

  initial begin
    item.valid = 0;
    item.operation = OP_TICK;
    item.target_position = '0;
    item.elapsed_us = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values written back explicitly
    setup(0, 0, 16'd0, 16'h8000, 16'h7FFF, 8'd0, 16'd0);

    // directed: unused code, clamp extremes, tick extremes, settling, re-zero
    put(OP_SPARE, 32'hFFFF_FFFF, 16'hFFFF);
    put(OP_TICK, 32'h1234_5678, 16'd0);
    put(OP_MOVE, 32'h7FFF_FFFF, 16'hFFFF);
    put(OP_TICK, 32'd0, 16'd0);
    put(OP_TICK, 32'd0, 16'hFFFF);
    put(OP_TICK, 32'd0, 16'hFFFF);
    put(OP_MOVE, 32'h8000_0000, 16'd0);
    repeat (4) put(OP_TICK, 32'd0, 16'd3000);
    put(OP_MOVE, 32'd0, 16'd0);
    repeat (6) put(OP_TICK, 32'd0, 16'hFFFF);
    put(OP_REZERO, 32'hFFFF_FFFF, 16'hFFFF);
    put(OP_MOVE, 32'd2, 16'd0);
    repeat (5) put(OP_TICK, 32'd0, 16'd65535);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      case (ph)
        0: setup(0, 0, 16'd0, 16'h8000, 16'h7FFF, 8'd0, 16'd0);
        1: setup(1, 1, 16'd200, 16'h8000, 16'h7FFF, 8'd3, 16'hFFFB);
        2: setup(0, 1, 16'hFFFF, 16'd50, 16'hFFCE, 8'd255, 16'h7FFF);
        3: setup(0, 0, 16'd0, 16'hFF9C, 16'd100, 8'd0, 16'h8000);
        4: setup(1, 1, 16'd1, 16'h8000, 16'h7FFF, 8'd1, 16'd5);
        default: setup(0, 1, 16'd0, 16'hFFF0, 16'd16, 8'd0, 16'hFFFF);
      endcase
      if (ph == 2) begin
        // long hold-off while items keep coming, so the block backs up
        hold_req = 1;
        random_items(20);
      end
      random_items(300);
      drain();
    end

    recv_stall_pct = 0;
    repeat (50) @(posedge clk);
    $display("covered %0d items and %0d results over six register settings", sent, checked);
    $display("idle and stall mixes on both channels, one long result hold-off");
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
